// ===== design/twg_pkg.sv =====
// Shared constants, register codes and sine table function for the tone waveform generator.
// Used by twg_divider, twg_sine_rom and tone_waveform_generator. No dependencies.

package twg_pkg;

    // Default sizing of the sine table and phase
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int PHASE_BITS_DEF       = 12;

    // Field and register widths
    localparam int WAVE_W    = 2;
    localparam int PERIOD_W  = 16;
    localparam int VOL_W     = 15;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int ROM_W     = 16;
    localparam int FRAC_W    = 16;
    localparam int LEVEL_W   = 32;

    // Shared divider: 32-bit dividend, 16-bit divisor
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME   = 2'd2;

    // Waveform codes
    localparam logic [WAVE_W-1:0] WAVE_SINE    = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SAW     = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE  = 2'd2;
    localparam logic [WAVE_W-1:0] WAVE_SILENCE = 2'd3;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;
    localparam logic [VOL_W-1:0]    VOLUME_RST = 15'd3000;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 16'd2;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Q15 sine of angle x (Q30 radians, 0..pi/2), Taylor series through x^13
    function automatic logic [ROM_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        mag;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x2  = (x * x) >> 30;
        mag = x;
        sum = $signed(x);
        mag = ((mag * x2) >> 30) / 64'd6;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd20;
        sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd42;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd72;
        sum = sum + $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd110;
        sum = sum - $signed(mag);
        mag = ((mag * x2) >> 30) / 64'd156;
        sum = sum + $signed(mag);
        if (sum < 0) begin
            sum = '0;
        end
        rnd = ($unsigned(sum) + 64'd16384) >> 15;
        if (rnd > 64'd32768) begin
            rnd = 64'd32768;
        end
        return rnd[ROM_W-1:0];
    endfunction

endpackage

// ===== design/twg_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on twg_pkg for widths.

module twg_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [twg_pkg::DIV_W-1:0]       i_dividend,
    input  logic [twg_pkg::PERIOD_W-1:0]    i_divisor,
    output logic                            o_done,
    output logic [twg_pkg::DIV_W-1:0]       o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [twg_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [twg_pkg::PERIOD_W-1:0]   r_rem;
    logic [twg_pkg::PERIOD_W-1:0]   r_div;
    logic [twg_pkg::DIV_W-1:0]      r_quo;

    logic [twg_pkg::PERIOD_W:0]     rem_sh;
    logic                           fits;
    logic [twg_pkg::PERIOD_W:0]     rem_sub;

    // One step: shift in next dividend bit, trial subtract
    assign rem_sh  = {r_rem, r_quo[twg_pkg::DIV_W-1]};
    assign fits    = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= twg_pkg::DIV_CNT_W'(twg_pkg::DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[twg_pkg::PERIOD_W-1:0] : rem_sh[twg_pkg::PERIOD_W-1:0];
            r_quo <= {r_quo[twg_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/twg_sine_rom.sv =====
// Quarter-wave sine table, DEPTH+1 entries of Q15 magnitude, registered read.
// Depends on twg_pkg for the table function and widths.

module twg_sine_rom #(
    parameter int DEPTH  = twg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic [ADDR_W-1:0]           i_addr,
    output logic [twg_pkg::ROM_W-1:0]   o_data
);

    logic [twg_pkg::ROM_W-1:0] rom_tbl [0:DEPTH];
    logic [twg_pkg::ROM_W-1:0] r_data;

    // Table contents are fixed at elaboration
    for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
        localparam logic [63:0] LP_X = (twg_pkg::HALF_PI_Q30 * 64'(k)) / 64'(DEPTH);
        assign rom_tbl[k] = twg_pkg::sine_q15(LP_X);
    end

    always_ff @(posedge i_clk) begin
        r_data <= rom_tbl[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== design/tone_waveform_generator.sv =====
// Top level of the tone waveform generator: sequencer, registers and sample datapath.
// Depends on twg_pkg, twg_divider and twg_sine_rom.
//
//   channel   signals                                    direction
//   -------   ----------------------------------------   ---------
//   tick      i_valid, o_ready, i_buffer_start           in
//   sample    o_valid, i_ready, o_sample                 out
//   config    i_cfg_we, i_cfg_idx, i_cfg_data            in (write only)
//
// One tick at a time. Sine and sawtooth both go through the 32-step shared divider
// (phase for sine, level step for sawtooth), and sine then reads the table and scales;
// square and silence skip the divider. The result sits in an output register, so the next
// tick is taken while it waits. Reset is synchronous; no clearing pass is needed.

module tone_waveform_generator #(
    parameter int SINE_TABLE_DEPTH = twg_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int PHASE_BITS       = twg_pkg::PHASE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [twg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [twg_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_buffer_start,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [twg_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int QBITS   = PHASE_BITS - 2;
    localparam int IPROD_W = QBITS + ADDR_W;
    localparam int PROD_W  = twg_pkg::VOL_W + twg_pkg::ROM_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int LVL_W   = twg_pkg::LEVEL_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_DONE
    } t_state;

    // Configuration registers
    logic [twg_pkg::WAVE_W-1:0]     r_waveform;
    logic [twg_pkg::PERIOD_W-1:0]   r_period;
    logic [twg_pkg::VOL_W-1:0]      r_volume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform <= twg_pkg::WAVE_SINE;
            r_period   <= twg_pkg::PERIOD_RST;
            r_volume   <= twg_pkg::VOLUME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                twg_pkg::CFG_WAVEFORM: r_waveform <= i_cfg_data[twg_pkg::WAVE_W-1:0];
                twg_pkg::CFG_PERIOD:   r_period   <= i_cfg_data[twg_pkg::PERIOD_W-1:0];
                twg_pkg::CFG_VOLUME:   r_volume   <= i_cfg_data[twg_pkg::VOL_W-1:0];
                default: ;
            endcase
        end
    end

    t_state                                 r_state;
    logic                                   r_out_valid;
    logic signed [twg_pkg::SAMPLE_W-1:0]    r_sample;
    logic signed [twg_pkg::SAMPLE_W-1:0]    r_result;
    logic [twg_pkg::PERIOD_W-1:0]           r_frame_count;
    logic signed [twg_pkg::LEVEL_W-1:0]     r_saw_level;
    logic [PROD_W-1:0]                      r_prod;

    logic                                   accept;
    logic                                   out_load;
    logic                                   div_start;
    logic                                   div_done;
    logic [twg_pkg::DIV_W-1:0]              div_dividend;
    logic [twg_pkg::DIV_W-1:0]              div_quot;

    // Effective period and frame for the incoming tick
    logic [twg_pkg::PERIOD_W-1:0]           period_eff;
    logic [twg_pkg::PERIOD_W-1:0]           frame_in;
    logic [twg_pkg::PERIOD_W-1:0]           frame_eff;
    logic [twg_pkg::PERIOD_W:0]             frame_inc;
    logic [twg_pkg::PERIOD_W-1:0]           n_frame;
    logic [twg_pkg::PERIOD_W:0]             half_period;
    logic signed [twg_pkg::LEVEL_W-1:0]     vol_fx;
    logic signed [twg_pkg::LEVEL_W-1:0]     n_level;
    logic signed [twg_pkg::SAMPLE_W-1:0]    vol_pos;
    logic signed [twg_pkg::SAMPLE_W-1:0]    quick_sample;

    assign accept     = i_valid && (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign period_eff = (r_period < twg_pkg::PERIOD_MIN) ? twg_pkg::PERIOD_MIN : r_period;
    assign frame_in   = i_buffer_start ? '0 : r_frame_count;
    assign frame_eff  = (frame_in >= period_eff) ? '0 : frame_in;
    assign frame_inc  = {1'b0, frame_eff} + 1'b1;
    assign n_frame    = (frame_inc >= {1'b0, period_eff}) ? '0
                                                          : frame_inc[twg_pkg::PERIOD_W-1:0];
    assign half_period = ({1'b0, period_eff} + 1'b1) >> 1;
    assign vol_fx     = $signed({1'b0, r_volume, {twg_pkg::FRAC_W{1'b0}}});
    assign n_level    = i_buffer_start ? vol_fx : r_saw_level;
    assign vol_pos    = $signed({1'b0, r_volume});

    // Square and silence finish at once
    always_comb begin
        case (r_waveform)
            twg_pkg::WAVE_SQUARE:
                quick_sample = ({1'b0, frame_eff} < half_period) ? vol_pos : -vol_pos;
            default:
                quick_sample = '0;
        endcase
    end

    // Divider operands: phase for sine, 2*volume in 16.16 for sawtooth
    assign div_start    = accept && ((r_waveform == twg_pkg::WAVE_SINE) ||
                                     (r_waveform == twg_pkg::WAVE_SAW));
    assign div_dividend = (r_waveform == twg_pkg::WAVE_SINE)
                        ? (twg_pkg::DIV_W'(frame_eff) << PHASE_BITS)
                        : {r_volume, 1'b0, {twg_pkg::FRAC_W{1'b0}}};

    twg_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (period_eff),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Phase to quadrant and table address
    logic [PHASE_BITS-1:0]      phase;
    logic [1:0]                 quad;
    logic [QBITS-1:0]           phase_low;
    logic [IPROD_W-1:0]         idx_prod;
    logic [ADDR_W-1:0]          idx_raw;
    logic [ADDR_W-1:0]          idx;
    logic [ADDR_W-1:0]          rom_addr;
    logic [twg_pkg::ROM_W-1:0]  rom_data;

    assign phase     = div_quot[PHASE_BITS-1:0];
    assign quad      = phase[PHASE_BITS-1:PHASE_BITS-2];
    assign phase_low = phase[QBITS-1:0];
    assign idx_prod  = IPROD_W'(phase_low) * IPROD_W'(SINE_TABLE_DEPTH);
    assign idx_raw   = ADDR_W'(idx_prod >> QBITS);
    assign idx       = (idx_raw > ADDR_W'(SINE_TABLE_DEPTH)) ? ADDR_W'(SINE_TABLE_DEPTH) : idx_raw;
    assign rom_addr  = quad[0] ? (ADDR_W'(SINE_TABLE_DEPTH) - idx) : idx;

    twg_sine_rom #(
        .DEPTH  (SINE_TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // Sine magnitude rounding
    logic [SUM_W-1:0]                   prod_rnd;
    logic [twg_pkg::VOL_W-1:0]          sine_mag;
    logic signed [twg_pkg::SAMPLE_W-1:0] sine_sample;

    assign prod_rnd    = {1'b0, r_prod} + SUM_W'(16384);
    assign sine_mag    = prod_rnd[15 +: twg_pkg::VOL_W];
    assign sine_sample = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    // Sawtooth step with wrap back to the top
    logic signed [LVL_W-1:0]                lvl_sub;
    logic signed [LVL_W-1:0]                lvl_floor;
    logic signed [LVL_W-1:0]                lvl_new;
    logic signed [LVL_W-1:0]                lvl_neg;
    logic signed [twg_pkg::SAMPLE_W-1:0]    saw_sample;

    assign lvl_sub   = $signed({r_saw_level[twg_pkg::LEVEL_W-1], r_saw_level})
                     - $signed({1'b0, div_quot});
    assign lvl_floor = -$signed({vol_fx[twg_pkg::LEVEL_W-1], vol_fx});
    assign lvl_new   = (lvl_sub < lvl_floor) ? $signed({vol_fx[twg_pkg::LEVEL_W-1], vol_fx})
                                             : lvl_sub;
    assign lvl_neg   = -lvl_new;
    assign saw_sample = lvl_new[LVL_W-1]
                      ? -$signed({1'b0, lvl_neg[twg_pkg::FRAC_W +: twg_pkg::VOL_W]})
                      : $signed({1'b0, lvl_new[twg_pkg::FRAC_W +: twg_pkg::VOL_W]});

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_frame_count <= '0;
            r_saw_level   <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_frame_count <= n_frame;
                        r_saw_level   <= n_level;
                        r_result      <= quick_sample;
                        r_state       <= div_start ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_waveform == twg_pkg::WAVE_SINE) begin
                            r_state <= S_MUL;
                        end else begin
                            r_saw_level <= lvl_new[twg_pkg::LEVEL_W-1:0];
                            r_result    <= saw_sample;
                            r_state     <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_volume) * PROD_W'(rom_data);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_result <= sine_sample;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_sample <= r_result;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;

endmodule
